// ----- hdl/efv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efv_pkg: shared types and constants
// Status codes, header layout, CRC-32 byte update and the interface structs
// of the envelope frame validator.
// ----------------------------------------------------------------------------
package efv_pkg;

    localparam int COUNT_BITS = 32;
    localparam int POS_W      = COUNT_BITS + 1;

    localparam logic [63:0] SMAX = (64'd1 << COUNT_BITS) - 64'd1;

    localparam logic [5:0] HDR_BYTES    = 6'd40;
    localparam logic [3:0] SEC_HDR_BYTES = 4'd12;
    localparam logic [3:0] TAG_BYTES    = 4'd4;

    localparam logic [31:0] CRC_POLY     = 32'hedb88320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hffffffff;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TRUNCATED = 4'd1;
    localparam logic [3:0] ST_TRAILING  = 4'd2;
    localparam logic [3:0] ST_MAGIC     = 4'd3;
    localparam logic [3:0] ST_VERSION   = 4'd4;
    localparam logic [3:0] ST_FLAGS     = 4'd5;
    localparam logic [3:0] ST_HDRLEN    = 4'd6;
    localparam logic [3:0] ST_RESERVED  = 4'd7;
    localparam logic [3:0] ST_OVERFLOW  = 4'd8;
    localparam logic [3:0] ST_LIMIT     = 4'd9;
    localparam logic [3:0] ST_CRC       = 4'd10;

    localparam logic [7:0] REG_EXP_MAJOR = 8'd0;
    localparam logic [7:0] REG_EXP_MINOR = 8'd1;
    localparam logic [7:0] REG_SUP_FLAGS = 8'd2;
    localparam logic [7:0] REG_MAX_PAYLD = 8'd3;

    localparam logic [63:0] MAGIC_WORD = 64'h00314d5249484d43;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             in_payload;
        logic [POS_W-1:0] offset;
        logic             magic_ok;
        logic [15:0]      major;
        logic [15:0]      minor;
        logic [31:0]      flags;
        logic [31:0]      hdr_len;
        logic             rsv_nz;
        logic [63:0]      declared;
        logic [31:0]      stored_crc;
    } t_hdr;

    typedef struct packed {
        logic [31:0] crc;
        logic        sec_err;
        logic [3:0]  sec_cnt;
    } t_sec;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// ----- hdl/efv_header.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efv_header: byte position and header capture
// Tracks the position in the frame and collects the 40-byte header fields.
// ----------------------------------------------------------------------------
module efv_header (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic                i_last,
    input  logic [7:0]          i_byte,
    output efv_pkg::t_hdr       o_hdr
);

    logic [efv_pkg::POS_W-1:0] r_pos;
    logic        r_magic_ok;
    logic [15:0] r_major;
    logic [15:0] r_minor;
    logic [31:0] r_flags;
    logic [31:0] r_hdr_len;
    logic        r_rsv_nz;
    logic [63:0] r_declared;
    logic [31:0] r_crc;

    logic        in_hdr;
    logic [63:0] pl_off;
    logic        rsv_byte;

    assign in_hdr = (r_pos < efv_pkg::POS_W'(efv_pkg::HDR_BYTES));
    assign pl_off = 64'(r_pos) - 64'(efv_pkg::HDR_BYTES);

    // current byte lands in a reserved word and is nonzero
    assign rsv_byte = ((r_pos >= 20 && r_pos < 24) || (r_pos >= 36 && r_pos < 40)) &&
                      (i_byte != 8'd0);

    always_comb begin
        o_hdr            = '0;
        o_hdr.pos        = r_pos;
        o_hdr.in_payload = !in_hdr && (pl_off < r_declared);
        o_hdr.offset     = pl_off[efv_pkg::POS_W-1:0];
        o_hdr.magic_ok   = r_magic_ok;
        o_hdr.major      = r_major;
        o_hdr.minor      = r_minor;
        o_hdr.flags      = r_flags;
        o_hdr.hdr_len    = r_hdr_len;
        // fold in the byte being taken so a last byte in the header sees itself
        o_hdr.rsv_nz     = r_rsv_nz || rsv_byte;
        o_hdr.declared   = r_declared;
        o_hdr.stored_crc = r_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_acc && i_last)) begin
            r_pos      <= '0;
            r_magic_ok <= 1'b1;
            r_major    <= '0;
            r_minor    <= '0;
            r_flags    <= '0;
            r_hdr_len  <= '0;
            r_rsv_nz   <= 1'b0;
            r_declared <= '0;
            r_crc      <= '0;
        end else if (i_acc) begin
            if (!r_pos[efv_pkg::POS_W-1]) begin
                r_pos <= r_pos + efv_pkg::POS_W'(1);
            end
            if (in_hdr) begin
                priority if (r_pos < 8) begin
                    if (i_byte != efv_pkg::MAGIC_WORD[8*r_pos[2:0] +: 8]) begin
                        r_magic_ok <= 1'b0;
                    end
                end else if (r_pos < 10) begin
                    r_major[8*r_pos[0] +: 8] <= i_byte;
                end else if (r_pos < 12) begin
                    r_minor[8*r_pos[0] +: 8] <= i_byte;
                end else if (r_pos < 16) begin
                    r_flags[8*r_pos[1:0] +: 8] <= i_byte;
                end else if (r_pos < 20) begin
                    r_hdr_len[8*r_pos[1:0] +: 8] <= i_byte;
                end else if (r_pos < 24) begin
                    if (i_byte != 8'd0) r_rsv_nz <= 1'b1;
                end else if (r_pos < 32) begin
                    r_declared[8*r_pos[2:0] +: 8] <= i_byte;
                end else if (r_pos < 36) begin
                    r_crc[8*r_pos[1:0] +: 8] <= i_byte;
                end else begin
                    if (i_byte != 8'd0) r_rsv_nz <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hdl/efv_payload.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efv_payload: payload CRC and section walk
// Runs the reflected CRC-32 and the section tag/length walker per byte.
// ----------------------------------------------------------------------------
module efv_payload (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  logic          i_last,
    input  logic [7:0]    i_byte,
    input  efv_pkg::t_hdr i_hdr,
    output efv_pkg::t_sec o_next
);

    localparam int CB = efv_pkg::COUNT_BITS;

    logic [31:0]   r_crc, n_crc;
    logic          r_err, n_err;
    logic [3:0]    r_cnt, n_cnt;
    logic [63:0]   r_shift, n_shift;
    logic [CB-1:0] r_rem, n_rem;

    logic [3:0]    cnt_inc;
    logic [2:0]    lane;
    logic [CB+1:0] cursor;
    logic [CB+1:0] span;
    logic [CB-1:0] rem_dec;

    always_comb begin
        n_crc   = r_crc;
        n_err   = r_err;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_rem   = r_rem;
        cnt_inc = r_cnt + 4'd1;
        lane    = 3'(r_cnt - efv_pkg::TAG_BYTES);
        cursor  = (CB+2)'(i_hdr.offset) + (CB+2)'(1);
        span    = '0;
        rem_dec = r_rem - CB'(1);
        if (i_hdr.in_payload) begin
            n_crc = efv_pkg::crc_byte(r_crc, i_byte);
            if (!r_err) begin
                if (r_cnt < efv_pkg::SEC_HDR_BYTES) begin
                    if (r_cnt == 4'd0) n_shift = '0;
                    if (r_cnt >= efv_pkg::TAG_BYTES) n_shift[8*lane +: 8] = i_byte;
                    n_cnt = cnt_inc;
                    if (cnt_inc == efv_pkg::SEC_HDR_BYTES) begin
                        span = (CB+2)'(n_shift[CB-1:0]) + cursor;
                        if (n_shift > efv_pkg::SMAX ||
                            span > (CB+2)'(efv_pkg::SMAX)) begin
                            n_err = 1'b1;
                        end else if (n_shift == 64'd0) begin
                            n_cnt = 4'd0;
                        end else begin
                            n_rem = n_shift[CB-1:0];
                        end
                    end
                end else begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) n_cnt = 4'd0;
                end
            end
        end
        o_next.crc     = n_crc;
        o_next.sec_err = n_err;
        o_next.sec_cnt = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_acc && i_last)) begin
            r_crc   <= efv_pkg::CRC_ALL_ONES;
            r_err   <= 1'b0;
            r_cnt   <= '0;
            r_shift <= '0;
            r_rem   <= '0;
        end else if (i_acc) begin
            r_crc   <= n_crc;
            r_err   <= n_err;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_rem   <= n_rem;
        end
    end

endmodule

// ----- hdl/envelope_frame_validator.sv -----
`timescale 1ns / 1ps
// Each accepted byte's result word is registered and shows in the next cycle.
// Throughput: one byte per cycle while o_stall is low; header capture, CRC-32
// and the section walker are all per-byte logic ahead of one result register.
// Reset: synchronous, active low; clears frame state, restores register
// defaults (major 1, minor 0, flags 0, payload limit all ones).
// ----------------------------------------------------------------------------
// envelope_frame_validator: streaming container checker
// Parses the 40-byte header, forwards payload bytes, checks CRC and sections
// and reports one status word on the last byte of each container.
// ----------------------------------------------------------------------------
module envelope_frame_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // byte input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_valid,
    output logic        o_report_valid,
    output logic [3:0]  o_status,
    output logic [15:0] o_major,
    output logic [15:0] o_minor,
    output logic [31:0] o_flags,
    output logic [31:0] o_body_length
);

    logic [15:0] r_exp_major;
    logic [15:0] r_exp_minor;
    logic [31:0] r_sup_flags;
    logic [31:0] r_max_payload;

    logic          acc;
    efv_pkg::t_hdr hdr;
    efv_pkg::t_sec sec;

    logic [63:0] total_len;
    logic [63:0] need;
    logic [3:0]  n_status;

    // Take a new word whenever the result register is free or drains now.
    assign o_stall = o_valid && i_stall;
    assign acc     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_major   <= 16'd1;
            r_exp_minor   <= 16'd0;
            r_sup_flags   <= 32'd0;
            r_max_payload <= 32'hffffffff;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                efv_pkg::REG_EXP_MAJOR: r_exp_major   <= i_cfg_data[15:0];
                efv_pkg::REG_EXP_MINOR: r_exp_minor   <= i_cfg_data[15:0];
                efv_pkg::REG_SUP_FLAGS: r_sup_flags   <= i_cfg_data;
                efv_pkg::REG_MAX_PAYLD: r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    efv_header u_header (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_last  (i_last),
        .i_byte  (i_data_byte),
        .o_hdr   (hdr)
    );

    efv_payload u_payload (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_last  (i_last),
        .i_byte  (i_data_byte),
        .i_hdr   (hdr),
        .o_next  (sec)
    );

    // Final status in the order of precedence; CRC and section state are
    // taken after this byte has been folded in.
    assign total_len = 64'(hdr.pos) + 64'd1;
    assign need      = 64'(efv_pkg::HDR_BYTES) + hdr.declared;

    always_comb begin
        priority if (total_len < 64'(efv_pkg::HDR_BYTES)) begin
            n_status = efv_pkg::ST_TRUNCATED;
        end else if (!hdr.magic_ok) begin
            n_status = efv_pkg::ST_MAGIC;
        end else if (hdr.major != r_exp_major || hdr.minor != r_exp_minor) begin
            n_status = efv_pkg::ST_VERSION;
        end else if ((hdr.flags & ~r_sup_flags) != 32'd0) begin
            n_status = efv_pkg::ST_FLAGS;
        end else if (hdr.hdr_len != 32'(efv_pkg::HDR_BYTES)) begin
            n_status = efv_pkg::ST_HDRLEN;
        end else if (hdr.rsv_nz) begin
            n_status = efv_pkg::ST_RESERVED;
        end else if (hdr.declared > efv_pkg::SMAX - 64'(efv_pkg::HDR_BYTES)) begin
            n_status = efv_pkg::ST_OVERFLOW;
        end else if (hdr.declared > 64'(r_max_payload)) begin
            n_status = efv_pkg::ST_LIMIT;
        end else if (need > total_len) begin
            n_status = efv_pkg::ST_TRUNCATED;
        end else if (need < total_len) begin
            n_status = efv_pkg::ST_TRAILING;
        end else if ((sec.crc ^ efv_pkg::CRC_ALL_ONES) != hdr.stored_crc) begin
            n_status = efv_pkg::ST_CRC;
        end else if (sec.sec_err) begin
            n_status = efv_pkg::ST_OVERFLOW;
        end else if (sec.sec_cnt != 4'd0) begin
            n_status = efv_pkg::ST_TRUNCATED;
        end else begin
            n_status = efv_pkg::ST_OK;
        end
    end

    // Result register: hold while stalled, load on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (acc) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            o_payload_valid  <= hdr.in_payload;
            o_payload_byte   <= hdr.in_payload ? i_data_byte : 8'd0;
            o_report_valid   <= i_last;
            o_status         <= i_last ? n_status : efv_pkg::ST_OK;
            if (i_last && n_status == efv_pkg::ST_OK) begin
                o_major       <= hdr.major;
                o_minor       <= hdr.minor;
                o_flags       <= hdr.flags;
                o_body_length <= hdr.declared[31:0];
            end else begin
                o_major       <= '0;
                o_minor       <= '0;
                o_flags       <= '0;
                o_body_length <= '0;
            end
        end
    end

endmodule

// ----- hdl/efv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efv_checker: port-level assertions
// Checks result word consistency seen on the validator's ports.
// ----------------------------------------------------------------------------
module efv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic [7:0]  o_payload_byte,
    input logic        o_payload_valid,
    input logic        o_report_valid,
    input logic [3:0]  o_status,
    input logic [15:0] o_major,
    input logic [31:0] o_flags
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result valid after reset");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_payload_valid) |-> (o_payload_byte == 8'd0))
        else $error("payload byte not zeroed");

    a_status_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_report_valid) |-> (o_status == efv_pkg::ST_OK))
        else $error("status without report");

    a_fields_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != efv_pkg::ST_OK) |->
        (o_major == 16'd0 && o_flags == 32'd0))
        else $error("header fields on failed frame");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= efv_pkg::ST_CRC))
        else $error("status code out of range");

endmodule

bind envelope_frame_validator efv_checker u_efv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .o_payload_byte  (o_payload_byte),
    .o_payload_valid (o_payload_valid),
    .o_report_valid  (o_report_valid),
    .o_status        (o_status),
    .o_major         (o_major),
    .o_flags         (o_flags)
);
